// ----- rtl/core/hsv_pkg.sv -----
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies; every other file imports this package.
package hsv_pkg;

   localparam int CH_W  = 8;
   localparam int HUE_W = 15;
   localparam int SAT_W = 13;

   localparam int HUE_FRAC_BITS_DEF = 6;
   localparam int SAT_FRAC_BITS_DEF = 12;

   // hue degrees covered by one color sector
   localparam int HUE_DEG_PER_SECTOR = 60;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } hsv_req_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] saturation;
      logic [CH_W-1:0]  brightness;
   } hsv_rsp_type;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } hsv_sector_type;

   // per-pixel data that rides alongside the divider
   typedef struct packed {
      hsv_sector_type  sector;
      logic            neg;
      logic            gray;
      logic [CH_W-1:0] brightness;
   } hsv_side_type;

endpackage

// ----- rtl/core/hsv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes: hue divides
// by the color span, saturation by the brightness carried in the side word.
// Depends on hsv_pkg.
module hsv_div import hsv_pkg::*; #(
   parameter int QUO_W = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [CH_W+QUO_W-1:0] in_hue_num,
   input  logic [CH_W+QUO_W-1:0] in_sat_num,
   input  logic [CH_W-1:0]       in_den,
   input  hsv_side_type          in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [QUO_W-1:0]      out_hue_quo,
   output logic                  out_hue_rem_nz,
   output logic [QUO_W-1:0]      out_sat_quo,
   output hsv_side_type          out_side
);

   localparam int ACC_W = CH_W + QUO_W;

   // acc holds {partial remainder, numerator bits still to shift in / quotient so far}
   function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                 input logic [CH_W-1:0]  den);
      logic [CH_W:0] trial;
      logic [CH_W:0] diff;
      logic [ACC_W-1:0] res;
      trial = {acc[ACC_W-1:QUO_W], acc[QUO_W-1]};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         res = {diff[CH_W-1:0], acc[QUO_W-2:0], 1'b1};
      end else begin
         res = {trial[CH_W-1:0], acc[QUO_W-2:0], 1'b0};
      end
      return res;
   endfunction

   logic             valid_ff   [QUO_W];
   logic             src_valid  [QUO_W];
   logic             en         [QUO_W];
   logic [ACC_W-1:0] hue_acc_ff [QUO_W];
   logic [ACC_W-1:0] hue_acc_in [QUO_W];
   logic [ACC_W-1:0] sat_acc_ff [QUO_W];
   logic [ACC_W-1:0] sat_acc_in [QUO_W];
   logic [CH_W-1:0]  den_in     [QUO_W];
   logic [CH_W-1:0]  den_ff     [QUO_W-1];
   hsv_side_type     side_in    [QUO_W];
   hsv_side_type     side_ff    [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src_valid[k] = in_valid;
         assign den_in[k]    = in_den;
         assign side_in[k]   = in_side;
         assign hue_acc_in[k] = div_step(in_hue_num, in_den);
         assign sat_acc_in[k] = div_step(in_sat_num, in_side.brightness);
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign den_in[k]    = den_ff[k-1];
         assign side_in[k]   = side_ff[k-1];
         assign hue_acc_in[k] = div_step(hue_acc_ff[k-1], den_ff[k-1]);
         assign sat_acc_in[k] = div_step(sat_acc_ff[k-1], side_ff[k-1].brightness);
      end

      // a stage loads when empty or when its word moves on
      if (k == QUO_W-1) begin : g_last_en
         assign en[k] = !valid_ff[k] || out_ready;
      end else begin : g_mid_en
         assign en[k] = !valid_ff[k] || en[k+1];
         always_ff @(posedge clock) begin
            if (en[k]) begin
               den_ff[k] <= den_in[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en[k]) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            hue_acc_ff[k] <= hue_acc_in[k];
            sat_acc_ff[k] <= sat_acc_in[k];
            side_ff[k]    <= side_in[k];
         end
      end
   end

   assign in_ready       = en[0];
   assign out_valid      = valid_ff[QUO_W-1];
   assign out_hue_quo    = hue_acc_ff[QUO_W-1][QUO_W-1:0];
   assign out_hue_rem_nz = |hue_acc_ff[QUO_W-1][ACC_W-1:QUO_W];
   assign out_sat_quo    = sat_acc_ff[QUO_W-1][QUO_W-1:0];
   assign out_side       = side_ff[QUO_W-1];

endmodule

// ----- rtl/core/rgb_to_hsv_pixel_top.sv -----
// Top level of the RGB to HSV pixel converter.
// Depends on hsv_pkg and hsv_div.
//
// Converts one 8-bit RGB pixel per clock while the output is not stalled, to
// hue (1/2^HUE_FRAC_BITS degree), saturation (2^SAT_FRAC_BITS = 1.0) and
// brightness (largest channel). A pixel passes QUO_W + 4 register stages, where
// QUO_W is the larger of the hue quotient width and SAT_FRAC_BITS + 1; the
// divider retires one quotient bit per stage, which sets that depth. Every stage
// holds its own valid bit, so a stalled result only holds the stages behind it
// and bubbles ahead of the stall keep filling.
module rgb_to_hsv_pixel_top import hsv_pkg::*; #(
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
   parameter int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hsv_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hsv_rsp_type rsp_data
);

   localparam int HUE_UNIT = HUE_DEG_PER_SECTOR << HUE_FRAC_BITS;
   localparam int HUE_Q_W  = $clog2(HUE_UNIT + 1);
   localparam int SAT_Q_W  = SAT_FRAC_BITS + 1;
   localparam int QUO_W    = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;
   localparam int ACC_W    = CH_W + QUO_W;
   localparam int HUE_SUM_W = $clog2(6 * HUE_UNIT + 1);
   localparam int HC_A_W   = (HUE_SUM_W > HUE_W) ? HUE_SUM_W : HUE_W;
   localparam int HC_W     = (HC_A_W > QUO_W) ? HC_A_W : QUO_W;
   localparam int SC_W     = (QUO_W > SAT_W) ? QUO_W : SAT_W;

   // stage 0: input register
   logic        s0_valid_ff;
   logic        s0_en;
   hsv_req_type s0_pix_ff;

   // stage 1: max/min, sector, difference magnitude
   logic            s1_valid_ff;
   logic            s1_en;
   logic [CH_W-1:0] s1_delta_ff, s1_delta_in;
   logic [CH_W-1:0] s1_mag_ff, s1_mag_in;
   hsv_side_type    s1_side_ff, s1_side_in;

   // stage 2: numerators
   logic             s2_valid_ff;
   logic             s2_en;
   logic [ACC_W-1:0] s2_hue_num_ff, s2_hue_num_in;
   logic [ACC_W-1:0] s2_sat_num_ff, s2_sat_num_in;
   logic [CH_W-1:0]  s2_den_ff;
   hsv_side_type     s2_side_ff;

   // divider
   logic             div_in_ready;
   logic             div_out_valid;
   logic [QUO_W-1:0] div_hue_quo;
   logic             div_hue_rem_nz;
   logic [QUO_W-1:0] div_sat_quo;
   hsv_side_type     div_side;

   // output register
   logic        rsp_valid_ff;
   logic        out_en;
   hsv_rsp_type rsp_ff, rsp_in;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || div_in_ready;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign s0_en     = !s0_valid_ff || s1_en;
   assign req_ready = s0_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_en)  s0_valid_ff  <= req_valid;
         if (s1_en)  s1_valid_ff  <= s0_valid_ff;
         if (s2_en)  s2_valid_ff  <= s1_valid_ff;
         if (out_en) rsp_valid_ff <= div_out_valid;
      end
   end

   always_comb begin
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] mn;
      logic [CH_W-1:0] opa;
      logic [CH_W-1:0] opb;
      mx = s0_pix_ff.red;
      mn = s0_pix_ff.red;
      if (s0_pix_ff.green > mx) mx = s0_pix_ff.green;
      if (s0_pix_ff.blue > mx)  mx = s0_pix_ff.blue;
      if (s0_pix_ff.green < mn) mn = s0_pix_ff.green;
      if (s0_pix_ff.blue < mn)  mn = s0_pix_ff.blue;
      // red wins all ties, then green
      if (s0_pix_ff.red == mx) begin
         s1_side_in.sector = SECTOR_RED;
         opa = s0_pix_ff.green;
         opb = s0_pix_ff.blue;
      end else if (s0_pix_ff.green == mx) begin
         s1_side_in.sector = SECTOR_GREEN;
         opa = s0_pix_ff.blue;
         opb = s0_pix_ff.red;
      end else begin
         s1_side_in.sector = SECTOR_BLUE;
         opa = s0_pix_ff.red;
         opb = s0_pix_ff.green;
      end
      s1_side_in.neg        = opa < opb;
      s1_side_in.gray       = mx == mn;
      s1_side_in.brightness = mx;
      s1_mag_in   = (opa < opb) ? (opb - opa) : (opa - opb);
      s1_delta_in = mx - mn;
   end

   assign s2_hue_num_in = ACC_W'(HUE_UNIT) * ACC_W'(s1_mag_ff);
   assign s2_sat_num_in = ACC_W'(s1_delta_ff) << SAT_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (s0_en) begin
         s0_pix_ff <= req_data;
      end
      if (s1_en) begin
         s1_delta_ff <= s1_delta_in;
         s1_mag_ff   <= s1_mag_in;
         s1_side_ff  <= s1_side_in;
      end
      if (s2_en) begin
         s2_hue_num_ff <= s2_hue_num_in;
         s2_sat_num_ff <= s2_sat_num_in;
         s2_den_ff     <= s1_delta_ff;
         s2_side_ff    <= s1_side_ff;
      end
      if (out_en) begin
         rsp_ff <= rsp_in;
      end
   end

   hsv_div #(
      .QUO_W (QUO_W)
   ) u_div (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s2_valid_ff),
      .in_ready       (div_in_ready),
      .in_hue_num     (s2_hue_num_ff),
      .in_sat_num     (s2_sat_num_ff),
      .in_den         (s2_den_ff),
      .in_side        (s2_side_ff),
      .out_valid      (div_out_valid),
      .out_ready      (out_en),
      .out_hue_quo    (div_hue_quo),
      .out_hue_rem_nz (div_hue_rem_nz),
      .out_sat_quo    (div_sat_quo),
      .out_side       (div_side)
   );

   // floor of a negative quotient is minus the ceiling of its magnitude
   always_comb begin
      logic [HC_W-1:0] quo;
      logic [HC_W-1:0] ceil_quo;
      logic [HC_W-1:0] base;
      logic [HC_W-1:0] hue_full;
      logic [SC_W-1:0] sat_full;
      quo      = HC_W'(div_hue_quo);
      ceil_quo = quo + HC_W'(div_hue_rem_nz);
      case (div_side.sector)
         SECTOR_RED:   base = div_side.neg ? HC_W'(6 * HUE_UNIT) : '0;
         SECTOR_GREEN: base = HC_W'(2 * HUE_UNIT);
         SECTOR_BLUE:  base = HC_W'(4 * HUE_UNIT);
         default:      base = '0;
      endcase
      hue_full = div_side.neg ? (base - ceil_quo) : (base + quo);
      sat_full = SC_W'(div_sat_quo);
      if (div_side.gray) begin
         hue_full = '0;
         sat_full = '0;
      end
      rsp_in.hue        = hue_full[HUE_W-1:0];
      rsp_in.saturation = sat_full[SAT_W-1:0];
      rsp_in.brightness = div_side.brightness;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/hsv_checker.sv -----
// Port-level assertions for the RGB to HSV pixel converter, bound to the top.
// Depends on hsv_pkg and rgb_to_hsv_pixel_top.
module hsv_checker import hsv_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input hsv_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input hsv_rsp_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // back pressure on the input only comes from a stalled, full output
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a stalled result");

   // black is gray: no hue, no saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.brightness == '0 |-> rsp_data.hue == '0 && rsp_data.saturation == '0)
      else $error("black pixel with nonzero hue or saturation");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind rgb_to_hsv_pixel_top hsv_checker u_hsv_checker (.*);
